// ===== design/lmhc_pkg.sv =====
// Shared types, constants and the byte-wide CRC-32 step for the line metadata
// header checker. No dependencies; used by every module of the block except lmhc_checker.
`default_nettype none

package lmhc_pkg;

   localparam int unsigned OFF_W = 6;

   // record layout offsets
   localparam logic [OFF_W-1:0] OFF_ID_LO     = 6'd4;
   localparam logic [OFF_W-1:0] OFF_ID_HI     = 6'd7;
   localparam logic [OFF_W-1:0] OFF_TYPE_LO   = 6'd24;
   localparam logic [OFF_W-1:0] OFF_TYPE_HI   = 6'd25;
   localparam logic [OFF_W-1:0] OFF_VER_LO    = 6'd26;
   localparam logic [OFF_W-1:0] OFF_VER_HI    = 6'd27;
   localparam logic [OFF_W-1:0] OFF_LINE_LO   = 6'd28;
   localparam logic [OFF_W-1:0] OFF_LINE_HI   = 6'd31;
   localparam logic [OFF_W-1:0] OFF_PREV_LO   = 6'd36;
   localparam logic [OFF_W-1:0] OFF_PREV_HI   = 6'd39;
   localparam logic [OFF_W-1:0] OFF_SEQ_LO    = 6'd40;
   localparam logic [OFF_W-1:0] OFF_SEQ_HI    = 6'd47;
   localparam logic [OFF_W-1:0] OFF_WIN_LO    = 6'd48;
   localparam logic [OFF_W-1:0] OFF_LAST      = 6'd51;

   localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
   localparam logic [31:0] ID_RESET     = 32'h7062_6C6B;
   localparam logic [15:0] VER_RESET    = 16'h0001;
   localparam logic [31:0] PREV_ID_FIRST = 32'hFFFF_FFFF;

   // configuration register indexes
   localparam logic CSR_EXP_ID  = 1'b0;
   localparam logic CSR_EXP_VER = 1'b1;

   // completed record summary, front to back
   typedef struct packed {
      logic [31:0] stored_crc;
      logic [31:0] crc;
      logic [31:0] identifier;
      logic [15:0] version;
      logic [15:0] line_type;
      logic [31:0] line_id;
      logic [31:0] prev_id;
      logic        seq_zero;
      logic [31:0] window;
   } rec_type;

   // one result transaction
   typedef struct packed {
      logic [31:0] crc_computed;
      logic [31:0] window_luns;
      logic [15:0] line_type;
      logic [31:0] line_id;
      logic        first_ok;
      logic        header_ok;
   } rsp_type;

   // handshake between two stages
   typedef struct packed {
      logic valid;
      logic ready;
   } hs_type;

   // reflected CRC-32, one byte
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== design/lmhc_front.sv =====
// Front end: accepts record bytes, tracks offset, runs the CRC and captures fields.
// Depends on lmhc_pkg; pushes a finished record summary toward the queue.
`default_nettype none

module lmhc_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic             start_req,
   input  wire logic [7:0]       data_byte,
   output logic                  push,
   output lmhc_pkg::rec_type     rec
);
   import lmhc_pkg::*;

   logic [OFF_W-1:0] offset_ff, offset_in, off;
   logic [31:0]      crc_ff, crc_in, crc_cur;
   logic [31:0]      scrc_ff, scrc_in;
   logic [31:0]      ident_ff, ident_in;
   logic [15:0]      type_ff, type_in;
   logic [15:0]      ver_ff, ver_in;
   logic [31:0]      line_ff, line_in;
   logic [31:0]      prev_ff, prev_in;
   logic             seqz_ff, seqz_in;
   logic [31:0]      win_ff, win_in;
   logic [4:0]       lane4;
   logic [3:0]       lane2;

   assign lane4 = {off[1:0], 3'b000};
   assign lane2 = {off[0], 3'b000};

   always_comb begin
      // a start drops the old record before this byte is taken
      off      = start_req ? '0 : offset_ff;
      crc_cur  = start_req ? CRC_INIT : crc_ff;
      scrc_in  = start_req ? '0 : scrc_ff;
      ident_in = start_req ? '0 : ident_ff;
      type_in  = start_req ? '0 : type_ff;
      ver_in   = start_req ? '0 : ver_ff;
      line_in  = start_req ? '0 : line_ff;
      prev_in  = start_req ? '0 : prev_ff;
      seqz_in  = start_req ? 1'b1 : seqz_ff;
      win_in   = start_req ? '0 : win_ff;
      crc_in   = crc_cur;
      offset_in = off;
      if (off <= OFF_LAST) begin
         offset_in = off + 6'd1;
         if (off >= OFF_ID_LO && off <= OFF_LINE_HI) begin
            crc_in = crc_byte(crc_cur, data_byte);
         end
         if (off < OFF_ID_LO) begin
            scrc_in[lane4 +: 8] = data_byte;
         end else if (off <= OFF_ID_HI) begin
            ident_in[lane4 +: 8] = data_byte;
         end else if (off >= OFF_TYPE_LO && off <= OFF_TYPE_HI) begin
            type_in[lane2 +: 8] = data_byte;
         end else if (off >= OFF_VER_LO && off <= OFF_VER_HI) begin
            ver_in[lane2 +: 8] = data_byte;
         end else if (off >= OFF_LINE_LO && off <= OFF_LINE_HI) begin
            line_in[lane4 +: 8] = data_byte;
         end else if (off >= OFF_PREV_LO && off <= OFF_PREV_HI) begin
            prev_in[lane4 +: 8] = data_byte;
         end else if (off >= OFF_SEQ_LO && off <= OFF_SEQ_HI) begin
            if (data_byte != 8'd0) begin
               seqz_in = 1'b0;
            end
         end else if (off >= OFF_WIN_LO) begin
            win_in[lane4 +: 8] = data_byte;
         end
      end
   end

   assign push = accept && (off == OFF_LAST);

   always_comb begin
      rec.stored_crc = scrc_in;
      rec.crc        = crc_in;
      rec.identifier = ident_in;
      rec.version    = ver_in;
      rec.line_type  = type_in;
      rec.line_id    = line_in;
      rec.prev_id    = prev_in;
      rec.seq_zero   = seqz_in;
      rec.window     = win_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         crc_ff    <= CRC_INIT;
         scrc_ff   <= '0;
         ident_ff  <= '0;
         type_ff   <= '0;
         ver_ff    <= '0;
         line_ff   <= '0;
         prev_ff   <= '0;
         seqz_ff   <= 1'b1;
         win_ff    <= '0;
      end else if (accept) begin
         offset_ff <= offset_in;
         crc_ff    <= crc_in;
         scrc_ff   <= scrc_in;
         ident_ff  <= ident_in;
         type_ff   <= type_in;
         ver_ff    <= ver_in;
         line_ff   <= line_in;
         prev_ff   <= prev_in;
         seqz_ff   <= seqz_in;
         win_ff    <= win_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/lmhc_queue.sv =====
// Two-entry queue of finished record summaries between front and back.
// Depends on lmhc_pkg for the record type and handshake struct.
`default_nettype none

module lmhc_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  lmhc_pkg::rec_type      wr_rec,
   output lmhc_pkg::hs_type       wr_hs,
   input  wire logic              pop,
   output lmhc_pkg::rec_type      rd_rec,
   output lmhc_pkg::hs_type       rd_hs
);
   import lmhc_pkg::*;

   rec_type    mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;

   assign wr_hs.ready = (count_ff != 2'd2);
   assign wr_hs.valid = push;
   assign rd_hs.valid = (count_ff != 2'd0);
   assign rd_hs.ready = pop;
   assign rd_rec      = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/lmhc_back.sv =====
// Back end: holds the configuration registers, checks a record summary and
// drives the output register. Depends on lmhc_pkg.
`default_nettype none

module lmhc_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [31:0]      csr_wdata,
   input  lmhc_pkg::hs_type      q_hs,
   input  lmhc_pkg::rec_type     q_rec,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output lmhc_pkg::rsp_type     rsp
);
   import lmhc_pkg::*;

   logic [31:0] exp_id_ff;
   logic [15:0] exp_ver_ff;
   logic        valid_ff;
   rsp_type     rsp_ff, rsp_in;
   logic        hdr_ok;

   assign pop = q_hs.valid && (!valid_ff || rsp_ready);

   always_comb begin
      hdr_ok = (q_rec.identifier == exp_id_ff) && (q_rec.version == exp_ver_ff)
               && (q_rec.stored_crc == q_rec.crc);
      rsp_in.header_ok    = hdr_ok;
      rsp_in.first_ok     = hdr_ok && (q_rec.line_id == 32'd0)
                            && (q_rec.prev_id == PREV_ID_FIRST) && q_rec.seq_zero;
      rsp_in.line_id      = q_rec.line_id;
      rsp_in.line_type    = q_rec.line_type;
      rsp_in.window_luns  = q_rec.window;
      rsp_in.crc_computed = q_rec.crc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_id_ff  <= ID_RESET;
         exp_ver_ff <= VER_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_EXP_ID:  exp_id_ff  <= csr_wdata;
            CSR_EXP_VER: exp_ver_ff <= csr_wdata[15:0];
            default:     exp_id_ff  <= exp_id_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

// ===== design/line_meta_header_checker_core.sv =====
// A result transaction shows on rsp_ after the summary of the record whose byte at offset 51
// is accepted has passed the record queue and then the output register. Throughput: one
// byte per cycle; the front stalls only when the two-entry record queue is full, which
// takes a stalled result side.
// Reset (synchronous, active high) clears offset and captured fields, presets the CRC, empties the
// queue, drops rsp_tvalid and loads the identifier and version registers with defaults.
`default_nettype none

module line_meta_header_checker_core (
   input  wire logic          clock,
   input  wire logic          reset,
   // request stream: one record byte per transaction
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [7:0]    req_tdata,    // [7:0] data_byte
   input  wire logic          req_tuser,    // [0] start_req
   // result stream: one transaction per completed header
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [119:0]       rsp_tdata,    // [0] header_ok, [1] first_ok,
                                            // [33:2] line_id, [49:34] line_type,
                                            // [81:50] window_luns,
                                            // [113:82] crc_computed, [119:114] zero
   // configuration writes
   input  wire logic          csr_we,
   input  wire logic          csr_index,
   input  wire logic [31:0]   csr_wdata
);
   import lmhc_pkg::*;

   logic    accept;
   logic    push;
   logic    pop;
   rec_type front_rec;
   rec_type q_rec;
   hs_type  wr_hs;
   hs_type  rd_hs;
   rsp_type rsp;

   // Hold off new bytes only while the queue cannot take a finished record.
   assign req_tready = wr_hs.ready;
   assign accept     = req_tvalid && req_tready;

   // Front: offset tracking, CRC over bytes 4..31, field capture.
   lmhc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .start_req (req_tuser),
      .data_byte (req_tdata),
      .push      (push),
      .rec       (front_rec)
   );

   // Decouple front and back so either side may stall on its own.
   lmhc_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .wr_rec (front_rec),
      .wr_hs  (wr_hs),
      .pop    (pop),
      .rd_rec (q_rec),
      .rd_hs  (rd_hs)
   );

   // Back: compare against the configuration and register the result.
   lmhc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_hs      (rd_hs),
      .q_rec     (q_rec),
      .pop       (pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   // Pack the result fields, lowest field first, pad to whole bytes.
   assign rsp_tdata = {6'd0, rsp};

endmodule

`default_nettype wire

// ===== design/lmhc_checker.sv =====
// Port-level checks for line_meta_header_checker_core, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module lmhc_checker (
   input wire logic          clock,
   input wire logic          reset,
   input wire logic          rsp_tvalid,
   input wire logic          rsp_tready,
   input wire logic [119:0]  rsp_tdata
);

   // hold a stalled result transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result transaction dropped or changed while stalled");

   // no result right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a first line needs a good header
   a_first_needs_hdr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[0])
      else $error("first_ok without header_ok");

   // a first line carries line id zero
   a_first_line_id: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[33:2] == 32'd0)
      else $error("first_ok with nonzero line id");

   // padding bits stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[119:114] == 6'd0)
      else $error("result padding not zero");

endmodule

bind line_meta_header_checker_core lmhc_checker u_lmhc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
